FILE: src/thpc_pkg.sv
package thpc_pkg;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned FRONT_DEPTH = 4;
  localparam int unsigned DIV_W = 32;

  localparam logic [2:0] CFG_TEMP_TRIM = 3'd0;
  localparam logic [2:0] CFG_PRESS_TRIM_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_TRIM_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_HUM_TRIM = 3'd3;
  localparam logic [2:0] CFG_HUM_TRIM = 3'd4;
  localparam logic [2:0] CFG_HUM_ENABLE = 3'd5;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } trim_t;

  typedef struct packed {
    logic [31:0] fine;
    logic [15:0] temp;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
  } q_item_t;

  typedef struct packed {
    logic valid;
    q_item_t item;
  } q_port_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [16:0] hum;
    logic invalid;
    logic post_dbl;
  } div_tag_t;

  function automatic logic [31:0] asr(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul(logic [31:0] a, logic [31:0] b);
    logic [31:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx8(logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

endpackage

FILE: src/thpc_front.sv
module thpc_front
  import thpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [19:0] raw_t,
  input  logic [19:0] raw_p,
  input  logic [15:0] raw_h,
  input  trim_t       trims,
  output q_port_t     push
);

  logic [2:0]  vld;
  logic [31:0] s0_adc_t;
  logic [19:0] s0_p, s1_p, s2_p;
  logic [15:0] s0_h, s1_h, s2_h;
  logic [31:0] s1_ma, s1_mb, s2_v1, s2_m3;
  logic [31:0] a, b, fine, tt;
  logic [15:0] temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
    s0_adc_t <= {12'd0, raw_t};
    s0_p <= raw_p;
    s0_h <= raw_h;
    s1_ma <= mul(a, trims.t2);
    s1_mb <= mul(b, b);
    s1_p <= s0_p;
    s1_h <= s0_h;
    s2_v1 <= asr(s1_ma, 11);
    s2_m3 <= mul(asr(s1_mb, 12), trims.t3);
    s2_p <= s1_p;
    s2_h <= s1_h;
  end

  always_comb begin
    a = (s0_adc_t >> 3) - (trims.t1 << 1);
    b = (s0_adc_t >> 4) - trims.t1;
    fine = s2_v1 + asr(s2_m3, 14);
    tt = asr(mul(fine, 32'd5) + 32'd128, 8);
    if ($signed(tt) < -32'sd32768) begin
      temp = 16'h8000;
    end else if ($signed(tt) > 32'sd32767) begin
      temp = 16'h7fff;
    end else begin
      temp = tt[15:0];
    end
    push.valid = vld[2];
    push.item.fine = fine;
    push.item.temp = temp;
    push.item.adc_p = s2_p;
    push.item.adc_h = s2_h;
  end

endmodule

FILE: src/thpc_queue.sv
module thpc_queue
  import thpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_port_t push,
  output q_port_t head,
  output logic    nearly_full
);

  q_item_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0] count;
  logic pop;

  assign pop = (count != '0);
  assign head.valid = pop;
  assign head.item = mem[rd_ptr];
  assign nearly_full = (count >= (QPTR_W+1)'(QDEPTH - FRONT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push.valid) - (QPTR_W+1)'(pop);
    end
    if (push.valid) mem[wr_ptr] <= push.item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && !pop && count == (QPTR_W+1)'(QDEPTH)))
    else $error("queue overflow");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count mismatch");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!push.valid && pop) |=> count == $past(count) - 1'b1)
    else $error("queue drain mismatch");

endmodule

FILE: src/thpc_div.sv
module thpc_div
  import thpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  div_tag_t    in_tag,
  output logic        out_valid,
  output logic [31:0] quotient,
  output div_tag_t    out_tag
);

  logic [31:0] rem [DIV_W+1];
  logic [31:0] quo [DIV_W+1];
  logic [31:0] dvs [DIV_W+1];
  div_tag_t    tag [DIV_W+1];
  logic [DIV_W:0] vld;

  assign rem[0] = '0;
  assign quo[0] = dividend;
  assign dvs[0] = divisor;
  assign tag[0] = in_tag;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < DIV_W; k++) begin : g_step
    logic [32:0] r, r_sub;
    logic ge;
    always_comb begin
      r = {rem[k], quo[k][31]};
      r_sub = r - {1'b0, dvs[k]};
      ge = (r >= {1'b0, dvs[k]});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1] <= ge ? r_sub[31:0] : r[31:0];
      quo[k+1] <= {quo[k][30:0], ge};
      dvs[k+1] <= dvs[k];
      tag[k+1] <= tag[k];
    end
  end

  assign out_valid = vld[DIV_W];
  assign quotient = quo[DIV_W];
  assign out_tag = tag[DIV_W];

endmodule

FILE: src/thpc_back.sv
module thpc_back
  import thpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_port_t     head,
  input  trim_t       trims,
  input  logic        hum_en,
  output logic        res_valid,
  output logic [15:0] res_temp,
  output logic [19:0] res_press,
  output logic        res_invalid,
  output logic [16:0] res_hum
);

  logic [7:1] bv;
  logic [31:0] fine, pv1, pq, hx0;
  logic [31:0] b1_qq, b1_m5, b1_m2, b1_mh5, b1_m6, b1_mh3;
  logic [31:0] b2_v2a, b2_m3, b2_u, b2_mi, b2_m5, b2_m2;
  logic [31:0] b3_v2, b3_mp1, b3_u, b3_m;
  logic [31:0] b4_div, b4_pr, b4_x;
  logic [31:0] b5_div, b5_pr, b5_x, b5_ss;
  logic [31:0] b6_div, b6_pr, b6_x, b6_t;
  logic [31:0] b7_dividend, b7_div;
  div_tag_t    b7_tag;
  logic [15:0] b1_temp, b2_temp, b3_temp, b4_temp, b5_temp, b6_temp;
  logic [19:0] b1_p, b2_p, b3_p;
  logic [15:0] b1_h;
  logic [31:0] pv2, pv1b, hu, hfin;
  logic [16:0] hum17;
  logic        dv_valid;
  logic [31:0] dv_quo, pr;
  div_tag_t    dv_tag;
  logic [2:0]  av;
  logic [31:0] a1_pr, a1_t, a1_w2, a2_pr, a2_w1, a2_w2, fpr;
  div_tag_t    a1_tag, a2_tag;
  logic [19:0] press20;

  always_comb begin
    fine = head.item.fine;
    pv1 = asr(fine, 1) - 32'd64000;
    pq = asr(pv1, 2);
    hx0 = fine - 32'd76800;
    pv2 = asr(b2_v2a + (b2_m5 << 1), 2) + (trims.p4 << 16);
    pv1b = asr(asr(b2_m3, 3) + asr(b2_m2, 1), 18);
    hu = asr(((32'(b1_h) << 14) - (trims.h4 << 20) - b1_mh5) + 32'd16384, 15);
    hfin = b6_x - asr(b6_t, 4);
    if ($signed(hfin) < 0) begin
      hum17 = '0;
    end else if ($signed(hfin) > 32'sd419430400) begin
      hum17 = 17'd102400;
    end else begin
      hum17 = hfin[28:12];
    end
    if (!hum_en) hum17 = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else begin
      bv <= {bv[6:1], head.valid};
    end
    b1_qq <= mul(pq, pq);
    b1_m5 <= mul(pv1, trims.p5);
    b1_m2 <= mul(trims.p2, pv1);
    b1_mh5 <= mul(trims.h5, hx0);
    b1_m6 <= mul(hx0, trims.h6);
    b1_mh3 <= mul(hx0, trims.h3);
    b1_temp <= head.item.temp;
    b1_p <= head.item.adc_p;
    b1_h <= head.item.adc_h;

    b2_v2a <= mul(asr(b1_qq, 11), trims.p6);
    b2_m3 <= mul(trims.p3, asr(b1_qq, 13));
    b2_m5 <= b1_m5;
    b2_m2 <= b1_m2;
    b2_u <= hu;
    b2_mi <= mul(asr(b1_m6, 10), asr(b1_mh3, 11) + 32'd32768);
    b2_temp <= b1_temp;
    b2_p <= b1_p;

    b3_v2 <= pv2;
    b3_mp1 <= mul(32'd32768 + pv1b, trims.p1);
    b3_u <= b2_u;
    b3_m <= mul(asr(b2_mi, 10) + 32'd2097152, trims.h2);
    b3_temp <= b2_temp;
    b3_p <= b2_p;

    b4_div <= asr(b3_mp1, 15);
    b4_pr <= mul((32'd1048576 - 32'(b3_p)) - asr(b3_v2, 12), 32'd3125);
    b4_x <= mul(b3_u, asr(b3_m + 32'd8192, 14));
    b4_temp <= b3_temp;

    b5_div <= b4_div;
    b5_pr <= b4_pr;
    b5_x <= b4_x;
    b5_ss <= mul(asr(b4_x, 15), asr(b4_x, 15));
    b5_temp <= b4_temp;

    b6_div <= b5_div;
    b6_pr <= b5_pr;
    b6_x <= b5_x;
    b6_t <= mul(asr(b5_ss, 7), trims.h1);
    b6_temp <= b5_temp;

    b7_div <= b6_div;
    b7_dividend <= b6_pr[31] ? b6_pr : (b6_pr << 1);
    b7_tag.temp <= b6_temp;
    b7_tag.hum <= hum17;
    b7_tag.invalid <= (b6_div == '0);
    b7_tag.post_dbl <= b6_pr[31];
  end

  thpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bv[7]),
    .dividend  (b7_dividend),
    .divisor   (b7_div),
    .in_tag    (b7_tag),
    .out_valid (dv_valid),
    .quotient  (dv_quo),
    .out_tag   (dv_tag)
  );

  always_comb begin
    pr = dv_tag.post_dbl ? (dv_quo << 1) : dv_quo;
    fpr = a2_pr + asr(asr(a2_w1, 12) + asr(a2_w2, 13) + trims.p7, 4);
    if ($signed(fpr) < 0) begin
      press20 = '0;
    end else if ($signed(fpr) > 32'sd1048575) begin
      press20 = 20'hfffff;
    end else begin
      press20 = fpr[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= '0;
    end else begin
      av <= {av[1:0], dv_valid};
    end
    a1_pr <= pr;
    a1_t <= mul(pr >> 3, pr >> 3);
    a1_w2 <= mul(pr >> 2, trims.p8);
    a1_tag <= dv_tag;
    a2_pr <= a1_pr;
    a2_w1 <= mul(trims.p9, a1_t >> 13);
    a2_w2 <= a1_w2;
    a2_tag <= a1_tag;
    res_temp <= a2_tag.temp;
    res_hum <= a2_tag.hum;
    res_invalid <= a2_tag.invalid;
    res_press <= a2_tag.invalid ? '0 : press20;
  end

  assign res_valid = av[2];

endmodule

FILE: src/thp_sensor_compensation.sv
// Compensates one raw temperature/pressure/humidity reading per item with the
// 32-bit integer trim scheme. An item is taken whenever start is high and busy
// is low; a new item may be given every cycle while busy is low. Each result
// appears for one cycle with strobe high, in the order taken; the receiver
// cannot stall, so results are never held back. Most of the pipeline's stages
// are in the 32-stage pipelined pressure divider. Trim registers and
// humidity_enable are written through write_enable/write_index/write_data and
// must only change while no item is in flight.
module thp_sensor_compensation
  import thpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  logic [15:0] raw_humidity,
  input  logic        write_enable,
  input  logic [2:0]  write_index,
  input  logic [63:0] write_data,
  output logic        strobe,
  output logic signed [15:0] temperature,
  output logic [19:0] pressure,
  output logic        pressure_invalid,
  output logic [16:0] humidity
);

  logic [47:0] temp_trim;
  logic [63:0] press_trim_a;
  logic [63:0] press_trim_b;
  logic [47:0] press_hum_trim;
  logic [39:0] hum_trim;
  logic        humidity_enable;
  trim_t       trims;
  q_port_t     push, head;
  logic        nearly_full;
  logic [15:0] res_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim <= '0;
      press_trim_a <= '0;
      press_trim_b <= '0;
      press_hum_trim <= '0;
      hum_trim <= '0;
      humidity_enable <= 1'b0;
    end else if (write_enable) begin
      case (write_index)
        CFG_TEMP_TRIM: temp_trim <= write_data[47:0];
        CFG_PRESS_TRIM_A: press_trim_a <= write_data;
        CFG_PRESS_TRIM_B: press_trim_b <= write_data;
        CFG_PRESS_HUM_TRIM: press_hum_trim <= write_data[47:0];
        CFG_HUM_TRIM: hum_trim <= write_data[39:0];
        CFG_HUM_ENABLE: humidity_enable <= write_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trims.t1 = {16'd0, temp_trim[15:0]};
    trims.t2 = sx16(temp_trim[31:16]);
    trims.t3 = sx16(temp_trim[47:32]);
    trims.p1 = {16'd0, press_trim_a[15:0]};
    trims.p2 = sx16(press_trim_a[31:16]);
    trims.p3 = sx16(press_trim_a[47:32]);
    trims.p4 = sx16(press_trim_a[63:48]);
    trims.p5 = sx16(press_trim_b[15:0]);
    trims.p6 = sx16(press_trim_b[31:16]);
    trims.p7 = sx16(press_trim_b[47:32]);
    trims.p8 = sx16(press_trim_b[63:48]);
    trims.p9 = sx16(press_hum_trim[15:0]);
    trims.h1 = {24'd0, press_hum_trim[23:16]};
    trims.h2 = sx16(press_hum_trim[39:24]);
    trims.h3 = {24'd0, press_hum_trim[47:40]};
    trims.h4 = sx16(hum_trim[15:0]);
    trims.h5 = sx16(hum_trim[31:16]);
    trims.h6 = sx8(hum_trim[39:32]);
  end

  assign busy = nearly_full;

  thpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .raw_t    (raw_temperature),
    .raw_p    (raw_pressure),
    .raw_h    (raw_humidity),
    .trims    (trims),
    .push     (push)
  );

  thpc_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .head        (head),
    .nearly_full (nearly_full)
  );

  thpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .trims       (trims),
    .hum_en      (humidity_enable),
    .res_valid   (strobe),
    .res_temp    (res_temp),
    .res_press   (pressure),
    .res_invalid (pressure_invalid),
    .res_hum     (humidity)
  );

  assign temperature = $signed(res_temp);

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && pressure_invalid) |-> (pressure == '0))
    else $error("invalid pressure not zeroed");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (humidity <= 17'd102400))
    else $error("humidity out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("result strobe right after reset");

endmodule
